### hdl/twaa_pkg.sv
// shared types and constants for the timestamped window angle average
// no dependencies; imported by the top level and its checker
package twaa_pkg;

  localparam int DEFAULT_SAMPLE_DEPTH = 64;
  localparam int ANGLE_W              = 32;
  localparam int TIME_W               = 32;
  localparam int CAL_TIME_W           = 16;
  localparam logic [CAL_TIME_W-1:0] CAL_TIME_RESET = 16'd5000;

  typedef enum logic [1:0] {
    OP_RECORD    = 2'd0,
    OP_AVERAGE   = 2'd1,
    OP_EVICT_AVG = 2'd2,
    OP_CALIBRATE = 2'd3
  } twaa_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_RD,
    ST_EV_CHK,
    ST_REC,
    ST_DROP,
    ST_WR,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } twaa_state_t;

endpackage

### hdl/timestamped_window_angle_average.sv
// top level of the timestamped window angle average
// depends on twaa_pkg and twaa_ram
//
//  channel  | direction | word contents (lowest bit first)
//  ---------+-----------+-----------------------------------------------------
//  s_*      | in        | tuser: op; tdata: now, angle_in, max_age
//  m_*      | out       | tdata: angle_out, calibrating, sample_count, dropped_oldest
//  cfg_*    | in        | calibration_time, written whenever cfg_wen is high
//
//  one word at a time: s_tready is high only while the sequencer is idle
//  op 3 goes from idle straight to output; other ops pass the record state, which sends
//  calibrating items to output; else a full ring first drops its oldest sample, and the
//  sample is written; op 0 then goes to output, ops 1 and 2 add a bit-serial divide of
//  sum by count, one quotient bit per cycle, then the finish state and output
//  op 2 first walks the stored samples through the single ram read port, a read state
//  and a check state per stored sample
//  rst is synchronous; the ram needs no clearing pass, only stored entries are read
//  a stalled result sits in the output register; the next word is taken meanwhile
module timestamped_window_angle_average
  import twaa_pkg::*;
#(
  parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH,
  localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1),
  localparam int OUT_BITS = ANGLE_W + CNT_W + 2,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration: calibration_time
  input  logic                   cfg_wen,
  input  logic [CAL_TIME_W-1:0]  cfg_wdata,
  // input words
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [95:0]            s_tdata,   // now[31:0], angle_in[63:32], max_age[95:64]
  input  logic [1:0]             s_tuser,   // op
  // result words
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // angle_out, calibrating, sample_count, dropped_oldest
);

  localparam int IDX_W  = $clog2(SAMPLE_DEPTH);
  localparam int SUM_W  = ANGLE_W + IDX_W;
  localparam int ITER_W = $clog2(SUM_W);
  localparam int RAM_W  = TIME_W + ANGLE_W;
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(SAMPLE_DEPTH);
  localparam logic [IDX_W:0]   DEPTH_X    = (IDX_W + 1)'(SAMPLE_DEPTH);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

  // ring pointer step with wrap at the depth
  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W:0] nx;
    nx = {1'b0, p} + (IDX_W + 1)'(1);
    return (nx == DEPTH_X) ? '0 : nx[IDX_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sext(input logic [ANGLE_W-1:0] a);
    return {{(SUM_W - ANGLE_W){a[ANGLE_W-1]}}, a};
  endfunction

  twaa_state_t state, state_next;

  // item registers
  twaa_op_t               op;
  logic [TIME_W-1:0]      now;
  logic [ANGLE_W-1:0]     angle;
  logic [TIME_W-1:0]      threshold;

  // ring state
  logic [IDX_W-1:0]       oldest;
  logic [CNT_W-1:0]       count;
  logic [SUM_W-1:0]       sum;
  logic                   cal_flag;
  logic [TIME_W-1:0]      cal_start;
  logic [CAL_TIME_W-1:0]  cal_time;

  // eviction walk
  logic [CNT_W-1:0]       walk;
  logic [CNT_W-1:0]       kept;
  logic [IDX_W-1:0]       src_ptr;
  logic [IDX_W-1:0]       dst_ptr;

  // divider
  logic [SUM_W-1:0]       dvd;
  logic [CNT_W-1:0]       rem;
  logic                   div_neg;
  logic [ITER_W-1:0]      iter;

  // result
  logic [ANGLE_W-1:0]     result;
  logic                   dropped;

  // ram port
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [RAM_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [RAM_W-1:0]       ram_rdata;

  // input field views
  twaa_op_t               in_op;
  logic [TIME_W-1:0]      in_now;
  logic [ANGLE_W-1:0]     in_angle;
  logic [TIME_W-1:0]      in_max_age;
  logic [TIME_W-1:0]      cal_elapsed;
  logic                   cal_still;

  // helpers
  logic [IDX_W:0]         slot_sum;
  logic [IDX_W-1:0]       slot;
  logic [ANGLE_W-1:0]     rd_angle;
  logic [TIME_W-1:0]      rd_time;
  logic                   keep;
  logic [CNT_W:0]         trial;
  logic                   trial_ge;
  logic [SUM_W-1:0]       quot;
  logic                   out_free;

  assign in_op       = twaa_op_t'(s_tuser);
  assign in_now      = s_tdata[31:0];
  assign in_angle    = s_tdata[63:32];
  assign in_max_age  = s_tdata[95:64];
  // calibration ends before the op when its time has run out
  assign cal_elapsed = in_now - cal_start;
  assign cal_still   = cal_flag && (cal_elapsed < {{(TIME_W - CAL_TIME_W){1'b0}}, cal_time});

  assign rd_angle = ram_rdata[ANGLE_W-1:0];
  assign rd_time  = ram_rdata[RAM_W-1:ANGLE_W];
  assign keep     = (rd_time >= threshold);

  // write slot is oldest + count, count below depth here
  assign slot_sum = {1'b0, oldest} + {1'b0, count[IDX_W-1:0]};
  assign slot     = (slot_sum >= DEPTH_X) ? IDX_W'(slot_sum - DEPTH_X) : slot_sum[IDX_W-1:0];

  // one restoring divide step per cycle
  assign trial    = {rem, dvd[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, count});
  assign quot     = div_neg ? (~dvd + SUM_W'(1)) : dvd;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  twaa_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and ram controls
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = dst_ptr;
    ram_wdata  = ram_rdata;
    ram_raddr  = oldest;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          priority if (in_op == OP_CALIBRATE) begin
            state_next = ST_OUT;
          end else if (in_op == OP_EVICT_AVG) begin
            state_next = ST_EV_RD;
          end else begin
            state_next = ST_REC;
          end
        end
      end
      ST_EV_RD: begin
        ram_raddr = src_ptr;
        state_next = (walk == count) ? ST_REC : ST_EV_CHK;
      end
      ST_EV_CHK: begin
        // survivors are packed down toward the oldest slot
        ram_we     = keep;
        ram_waddr  = dst_ptr;
        ram_wdata  = ram_rdata;
        state_next = ST_EV_RD;
      end
      ST_REC: begin
        ram_raddr = oldest;
        priority if (cal_flag) begin
          state_next = ST_OUT;
        end else if (count == COUNT_FULL) begin
          state_next = ST_DROP;
        end else begin
          state_next = ST_WR;
        end
      end
      ST_DROP: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = slot;
        ram_wdata  = {now, angle};
        state_next = (op == OP_RECORD) ? ST_OUT : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (iter == ITER_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      count     <= '0;
      sum       <= '0;
      cal_flag  <= 1'b0;
      cal_start <= '0;
      cal_time  <= CAL_TIME_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cal_time <= cfg_wdata;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op        <= in_op;
            now       <= in_now;
            angle     <= in_angle;
            // eviction threshold saturates at zero
            threshold <= (in_now >= in_max_age) ? (in_now - in_max_age) : '0;
            dropped   <= 1'b0;
            result    <= '0;
            walk      <= '0;
            kept      <= '0;
            src_ptr   <= oldest;
            dst_ptr   <= oldest;
            if (in_op == OP_CALIBRATE && !cal_still) begin
              cal_flag  <= 1'b1;
              cal_start <= in_now;
            end else begin
              cal_flag  <= cal_still;
            end
          end
        end
        ST_EV_RD: begin
          if (walk == count) begin
            count <= kept;
            if (kept == '0) begin
              sum <= '0;
            end
          end
        end
        ST_EV_CHK: begin
          if (keep) begin
            dst_ptr <= ring_inc(dst_ptr);
            kept    <= kept + CNT_W'(1);
          end else begin
            sum <= sum - sext(rd_angle);
          end
          src_ptr <= ring_inc(src_ptr);
          walk    <= walk + CNT_W'(1);
        end
        ST_REC: begin
        end
        ST_DROP: begin
          // full ring gives up its oldest sample
          sum     <= sum - sext(rd_angle);
          oldest  <= ring_inc(oldest);
          count   <= COUNT_FULL - CNT_W'(1);
          dropped <= 1'b1;
        end
        ST_WR: begin
          count <= count + CNT_W'(1);
          sum   <= sum + sext(angle);
          if (op == OP_RECORD) begin
            result <= angle;
          end
        end
        ST_DIV_INIT: begin
          div_neg <= sum[SUM_W-1];
          dvd     <= sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
          rem     <= '0;
          iter    <= '0;
        end
        ST_DIV: begin
          rem  <= trial_ge ? CNT_W'(trial - {1'b0, count}) : trial[CNT_W-1:0];
          dvd  <= {dvd[SUM_W-2:0], trial_ge};
          iter <= iter + ITER_W'(1);
        end
        ST_FIN: begin
          // truncation toward zero: divide magnitudes, then restore the sign
          result <= quot[ANGLE_W-1:0];
        end
        ST_OUT: begin
        end
        default: begin
        end
      endcase

      // output register
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_TDATA_W'({dropped, count, cal_flag, result});
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### hdl/twaa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module twaa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/twaa_check.sv
// port-level checker for the timestamped window angle average, bound to the top level
// depends on twaa_pkg
module twaa_check
  import twaa_pkg::*;
#(
  parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH,
  localparam int CNT_W = $clog2(SAMPLE_DEPTH + 1),
  localparam int OUT_BITS = ANGLE_W + CNT_W + 2,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(SAMPLE_DEPTH);

  logic [ANGLE_W-1:0] w_angle;
  logic               w_cal;
  logic [CNT_W-1:0]   w_count;
  logic               w_dropped;

  assign w_angle   = m_tdata[ANGLE_W-1:0];
  assign w_cal     = m_tdata[ANGLE_W];
  assign w_count   = m_tdata[ANGLE_W+CNT_W:ANGLE_W+1];
  assign w_dropped = m_tdata[ANGLE_W+CNT_W+1];

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // one word in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in work");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> w_count <= COUNT_FULL)
    else $error("sample count above depth");

  a_cal_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && w_cal |-> w_angle == '0 && !w_dropped)
    else $error("nonzero angle or drop while calibrating");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && w_dropped |-> w_count == COUNT_FULL)
    else $error("drop flagged on a ring that is not full");

endmodule

bind timestamped_window_angle_average twaa_check #(
  .SAMPLE_DEPTH (SAMPLE_DEPTH)
) u_twaa_check (.*);

### dv/tb.sv
// self-checking bench for timestamped_window_angle_average: directed table, then random phases
// depends on twaa_pkg and the rtl top; carries its own window average predictor
module tb;
  import twaa_pkg::*;

  localparam int DEPTH = DEFAULT_SAMPLE_DEPTH;
  localparam int PHASE_ITEMS = 235;
  localparam int MAX_SHOWN = 10;

  // one result word, lowest field first: angle_out, calibrating, sample_count, dropped_oldest
  typedef struct packed {
    logic        dropped;
    logic [6:0]  count;
    logic        cal;
    logic [31:0] angle;
  } avg_result_t;

  localparam int RES_W = (($bits(avg_result_t) + 7) / 8) * 8;

  typedef struct {
    twaa_op_t    op;
    logic [31:0] now;
    logic [31:0] angle;
    logic [31:0] max_age;
    bit          fixed;
    avg_result_t want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wen = 1'b0;
  logic [15:0]      cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [95:0]      s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [RES_W-1:0] m_tdata;

  timestamped_window_angle_average #(
    .SAMPLE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: sample window ring, running sum, calibration
  logic signed [31:0] win_angle [DEPTH];
  logic [31:0]        win_time [DEPTH];
  int                 win_head = 0;
  int                 win_count = 0;
  longint             win_sum = 0;
  bit                 cal_active = 1'b0;
  logic [31:0]        cal_start = '0;
  logic [15:0]        cal_len = CAL_TIME_RESET;

  avg_result_t pending_results[$];
  int          fault_count = 0;
  int          shown = 0;

  function automatic avg_result_t predict_average(twaa_op_t op, logic [31:0] now,
                                                  logic signed [31:0] angle,
                                                  logic [31:0] max_age);
    avg_result_t res;
    logic [31:0] elapsed;
    logic [31:0] thresh;
    longint      avg;
    int          kept;
    int          src;
    int          dst;
    int          k;
    res = '0;
    elapsed = now - cal_start;
    // countdown is checked before the op, modulo 2^32
    if (cal_active && elapsed >= {16'd0, cal_len}) cal_active = 1'b0;
    if (op == OP_CALIBRATE) begin
      if (!cal_active) begin
        cal_active = 1'b1;
        cal_start = now;
      end
    end else begin
      if (op == OP_EVICT_AVG) begin
        thresh = (now >= max_age) ? now - max_age : '0;
        kept = 0;
        for (k = 0; k < win_count; k++) begin
          src = (win_head + k) % DEPTH;
          if (win_time[src] >= thresh) begin
            dst = (win_head + kept) % DEPTH;
            win_time[dst] = win_time[src];
            win_angle[dst] = win_angle[src];
            kept++;
          end else begin
            win_sum -= win_angle[src];
          end
        end
        win_count = kept;
        if (kept == 0) win_sum = 0;
      end
      if (!cal_active) begin
        // full ring gives up its oldest sample
        if (win_count >= DEPTH) begin
          win_sum -= win_angle[win_head];
          win_head = (win_head + 1) % DEPTH;
          win_count = DEPTH - 1;
          res.dropped = 1'b1;
        end
        dst = (win_head + win_count) % DEPTH;
        win_time[dst] = now;
        win_angle[dst] = angle;
        win_count++;
        win_sum += angle;
        if (op == OP_RECORD) begin
          res.angle = angle;
        end else begin
          avg = win_sum / win_count;
          res.angle = avg[31:0];
        end
      end
    end
    res.cal = cal_active;
    res.count = win_count[6:0];
    return res;
  endfunction

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic int burst_cycles();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 6);
    return $urandom_range(30, 200);
  endfunction

  // present one word, hold it until taken, then log what should come back
  task automatic send_word(twaa_op_t op, logic [31:0] now, logic [31:0] angle,
                           logic [31:0] max_age, bit fixed, avg_result_t want, int gap);
    avg_result_t res;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {max_age, angle, now};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    res = predict_average(op, now, angle, max_age);
    pending_results.insert(pending_results.size(), fixed ? want : res);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cal_time(logic [15:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cal_len = value;
  endtask

  task automatic add_row(ref stim_row_t rows[$], input twaa_op_t op, input logic [31:0] now,
                         input logic [31:0] angle, input logic [31:0] max_age,
                         input bit fixed, input avg_result_t want);
    stim_row_t row;
    row.op = op;
    row.now = now;
    row.angle = angle;
    row.max_age = max_age;
    row.fixed = fixed;
    row.want = want;
    rows.insert(rows.size(), row);
  endtask

  // result checker
  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t want;
    got = avg_result_t'(m_tdata[$bits(avg_result_t)-1:0]);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected word: angle %h cal %0d count %0d dropped %0d",
                   got.angle, got.cal, got.count, got.dropped);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.angle !== want.angle || got.cal !== want.cal ||
            got.count !== want.count || got.dropped !== want.dropped) begin
          fault_count++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("mismatch: expected angle %h cal %0d count %0d dropped %0d",
                     want.angle, want.cal, want.count, want.dropped);
            $display("          got      angle %h cal %0d count %0d dropped %0d",
                     got.angle, got.cal, got.count, got.dropped);
          end
        end
      end
    end
  end

  // receiver: runs of ready broken by stalls, sometimes long stretches with no stall
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat (burst_cycles()) @(posedge clk);
      gap = idle_cycles();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #8000000;
    $display("tb: errors");
    $finish;
  end

  initial begin
    stim_row_t   rows[$];
    int          cal_settings[6];
    logic [31:0] ms_clock;
    logic [31:0] now;
    logic [31:0] angle;
    logic [31:0] max_age;
    twaa_op_t    op;
    bit          src_steady;
    int          r;
    int          i;

    // directed rows; typed expectations are {dropped, count, cal, angle}
    add_row(rows, OP_RECORD, 100, 32'h7FFF_FFFF, 0, 1, {1'b0, 7'd1, 1'b0, 32'h7FFF_FFFF});
    // sum of -1 over two samples truncates to zero
    add_row(rows, OP_AVERAGE, 101, 32'h8000_0000, 0, 1, {1'b0, 7'd2, 1'b0, 32'h0});
    add_row(rows, OP_AVERAGE, 102, 32'hFFFF_FFFD, 0, 1, {1'b0, 7'd3, 1'b0, 32'hFFFF_FFFF});
    // zero age keeps only samples stamped now
    add_row(rows, OP_EVICT_AVG, 102, 32'd6, 0, 1, {1'b0, 7'd2, 1'b0, 32'd1});
    // age beyond now saturates the threshold to zero, later stamps stay
    add_row(rows, OP_EVICT_AVG, 50, 32'd0, 100, 1, {1'b0, 7'd3, 1'b0, 32'd1});
    add_row(rows, OP_EVICT_AVG, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, '0);
    add_row(rows, OP_CALIBRATE, 1000, 32'd12345, 0, 1, {1'b0, 7'd4, 1'b1, 32'h0});
    // calibrating: nothing recorded, angle forced to zero
    add_row(rows, OP_RECORD, 1001, 32'd5, 0, 1, {1'b0, 7'd4, 1'b1, 32'h0});
    add_row(rows, OP_AVERAGE, 1002, 32'hFFFF_FFF9, 0, 1, {1'b0, 7'd4, 1'b1, 32'h0});
    // eviction still runs while calibrating
    add_row(rows, OP_EVICT_AVG, 2000, 32'd9, 1, 0, '0);
    add_row(rows, OP_CALIBRATE, 3000, 32'd0, 0, 0, '0);
    add_row(rows, OP_RECORD, 5999, 32'd3, 0, 0, '0);
    add_row(rows, OP_RECORD, 6000, 32'hFFFF_0000, 0, 0, '0);
    add_row(rows, OP_AVERAGE, 6001, 32'h7FFF_FFFF, 0, 0, '0);
    add_row(rows, OP_EVICT_AVG, 6002, 32'h0, 32'hFFFF_FFFF, 0, '0);
    add_row(rows, OP_EVICT_AVG, 0, 32'h5555_5555, 0, 0, '0);
    add_row(rows, OP_EVICT_AVG, 7000, 32'hAAAA_AAAA, 0, 0, '0);
    add_row(rows, OP_EVICT_AVG, 32'hFFFF_FFFF, 32'd1, 0, 0, '0);
    // countdown across the 2^32 wrap
    add_row(rows, OP_CALIBRATE, 32'hFFFF_FFF0, 32'd0, 0, 0, '0);
    add_row(rows, OP_RECORD, 32'h0000_1000, 32'd2, 0, 0, '0);
    add_row(rows, OP_RECORD, 32'h0000_1400, 32'd4, 0, 0, '0);

    cal_settings = '{0, 65535, 1, 37, 5000, 0};
    cal_settings[5] = $urandom_range(2, 65534);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first rows run with the reset countdown length
    foreach (rows[j])
      send_word(rows[j].op, rows[j].now, rows[j].angle, rows[j].max_age,
                rows[j].fixed, rows[j].want, idle_cycles());

    src_steady = 1'b0;
    foreach (cal_settings[p]) begin
      drain_results();
      write_cal_time(cal_settings[p][15:0]);
      ms_clock = (p == 2) ? 32'hFFFF_F000 : $urandom;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) src_steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 34) op = OP_RECORD;
        else if (r < 62) op = OP_AVERAGE;
        else if (r < 95) op = OP_EVICT_AVG;
        else op = OP_CALIBRATE;
        // mostly steady time, rare jumps to end long countdowns
        if ($urandom_range(0, 99) < 2) ms_clock += $urandom_range(0, 100000);
        else ms_clock += $urandom_range(0, 8);
        now = ms_clock;
        if ($urandom_range(0, 49) == 0) now = $urandom;
        r = $urandom_range(0, 9);
        if (r < 5) angle = $urandom;
        else if (r < 9) angle = $urandom_range(0, 4000) - 2000;
        else begin
          case ($urandom_range(0, 3))
            0: angle = 32'h7FFF_FFFF;
            1: angle = 32'h8000_0000;
            2: angle = '0;
            default: angle = '1;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 55) max_age = $urandom_range(0, 1000);
        else if (r < 70) max_age = $urandom_range(0, 20000);
        else if (r < 80) max_age = $urandom_range(0, 30);
        else if (r < 87) max_age = '0;
        else if (r < 94) max_age = '1;
        else max_age = $urandom;
        send_word(op, now, angle, max_age, 1'b0, '0, src_steady ? 0 : idle_cycles());
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fault_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
